@@ rtl/olte_pkg.sv @@
`default_nettype none

package olte_pkg;

  // list geometry
  localparam int unsigned Depth    = 64;
  localparam int unsigned WordBits = 32;
  localparam int unsigned IdxW     = $clog2(Depth);
  localparam int unsigned CntW     = IdxW + 1;

  // fixed field widths of the ports
  localparam int unsigned CmdW    = 4;
  localparam int unsigned PosW    = 7;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned FidxW   = 6;
  localparam int unsigned EcntW   = 7;
  localparam int unsigned LimW    = 7;
  localparam int unsigned ApbDW   = 32;
  localparam int unsigned ApbAW   = 3;

  localparam logic [LimW-1:0] LimitReset = LimW'(64);

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [CmdW-1:0] {
    CmdPushBack  = 4'd0,
    CmdPopBack   = 4'd1,
    CmdPushFront = 4'd2,
    CmdPopFront  = 4'd3,
    CmdInsert    = 4'd4,
    CmdErase     = 4'd5,
    CmdFind      = 4'd6,
    CmdRemove    = 4'd7,
    CmdClear     = 4'd8
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StatOk       = 3'd0,
    StatFull     = 3'd1,
    StatEmpty    = 3'd2,
    StatBadPos   = 3'd3,
    StatNotFound = 3'd4
  } status_e;

  // broadcast to every cell
  typedef struct packed {
    logic shift_up;    // open a gap: cell at gap loads key, cells above take lower neighbor
    logic shift_down;  // close a gap: cells at and above gap take upper neighbor
    logic cmp_en;      // capture equality against key
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/olte_cell.sv @@
`default_nettype none

module olte_cell (
  input  wire                        clk_i,
  input  wire olte_pkg::cell_ctl_t   ctl_i,
  input  wire                        at_gt_i,   // this cell lies above the gap index
  input  wire                        at_eq_i,   // this cell is the gap index
  input  wire olte_pkg::word_t       key_i,
  input  wire olte_pkg::word_t       lo_data_i, // neighbor below
  input  wire olte_pkg::word_t       hi_data_i, // neighbor above
  output olte_pkg::word_t            data_o,
  output logic                       match_o
);

  olte_pkg::word_t data_q, data_d;
  logic            match_q;

  always_comb begin
    data_d = data_q;
    if (ctl_i.shift_up) begin
      if (at_eq_i) begin
        data_d = key_i;
      end else if (at_gt_i) begin
        data_d = lo_data_i;
      end
    end else if (ctl_i.shift_down) begin
      if (at_eq_i || at_gt_i) begin
        data_d = hi_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    if (ctl_i.cmp_en) begin
      match_q <= (data_q == key_i);
    end
  end

  assign data_o  = data_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

@@ rtl/ordered_list_table_engine_unit.sv @@
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        to block   in_valid_i / in_stall_o   cmd_i, position_i, value_i
// out       from block out_valid_o / out_stall_i status_o, found_index_o, entry_count_o,
//                                                is_empty_o
// config    to block   APB (psel, penable, ...)  capacity_limit at byte address 0
//
// Steps per item: accept, compare pass across the cells, apply/shift pass.
//   The compare result is registered in every cell before the first-match pick.
//   A new item is accepted only once the previous one has left the apply step.
// Reset: count cleared, capacity_limit set to 64, no result pending. Entries are
//   not cleared; only entries below the count are ever read.
// Stalls: the result sits in an output register; a new item is accepted while it
//   waits, and that item holds in the apply step until the register frees up.

module ordered_list_table_engine_unit (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // command items
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  [olte_pkg::CmdW-1:0]             cmd_i,
  input  wire  [olte_pkg::PosW-1:0]             position_i,
  input  wire  signed [olte_pkg::ValueW-1:0]    value_i,
  // result items
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [olte_pkg::StatusW-1:0]          status_o,
  output logic [olte_pkg::FidxW-1:0]            found_index_o,
  output logic [olte_pkg::EcntW-1:0]            entry_count_o,
  output logic                                  is_empty_o,
  // configuration
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [olte_pkg::ApbAW-1:0]            paddr,
  input  wire  [olte_pkg::ApbDW-1:0]            pwdata,
  output logic [olte_pkg::ApbDW-1:0]            prdata,
  output logic                                  pready
);

  localparam int unsigned Depth = olte_pkg::Depth;
  localparam int unsigned IdxW  = olte_pkg::IdxW;
  localparam int unsigned CntW  = olte_pkg::CntW;
  localparam int unsigned LimW  = olte_pkg::LimW;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StCmp   = 3'b010,
    StApply = 3'b100
  } state_e;

  state_e state_q, state_d;

  // ---------------------------------------------------------------- config
  logic [LimW-1:0] limit_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : olte_pkg::ApbDW'(limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= olte_pkg::LimitReset;
    end else if (cfg_wr) begin
      limit_q <= pwdata[LimW-1:0];
    end
  end

  // limit above depth acts as depth
  logic [CntW-1:0] limit_eff;
  assign limit_eff = ({1'b0, limit_q} > (LimW+1)'(Depth)) ? CntW'(Depth)
                                                           : CntW'(limit_q);

  // ---------------------------------------------------------------- command
  logic [olte_pkg::CmdW-1:0] cmd_q;
  logic [olte_pkg::PosW-1:0] pos_q;
  olte_pkg::word_t           key_q;
  logic [CntW-1:0]           count_q, count_d;
  logic                      accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      pos_q <= position_i;
      key_q <= olte_pkg::word_t'(value_i);
    end
  end

  // ---------------------------------------------------------------- cell chain
  olte_pkg::cell_ctl_t ctl;
  olte_pkg::word_t     cell_data [Depth];
  logic [Depth-1:0]    match_raw;
  logic [Depth-1:0]    at_gt, at_eq, live;
  logic [IdxW-1:0]     at;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    localparam logic [IdxW-1:0] CellIdx = IdxW'(i);
    olte_pkg::word_t lo_d, hi_d;

    assign at_gt[i] = (CellIdx > at);
    assign at_eq[i] = (CellIdx == at);
    assign live[i]  = ({1'b0, CellIdx} < count_q);

    if (i == 0) begin : g_lo_end
      assign lo_d = key_q;
    end else begin : g_lo_mid
      assign lo_d = cell_data[i-1];
    end
    if (i == Depth - 1) begin : g_hi_end
      assign hi_d = cell_data[i];
    end else begin : g_hi_mid
      assign hi_d = cell_data[i+1];
    end

    olte_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .at_gt_i   (at_gt[i]),
      .at_eq_i   (at_eq[i]),
      .key_i     (key_q),
      .lo_data_i (lo_d),
      .hi_data_i (hi_d),
      .data_o    (cell_data[i]),
      .match_o   (match_raw[i])
    );
  end

  // first match among live entries: isolate lowest set bit, then encode
  logic [Depth-1:0] match_vec, first_oh;
  logic             found;
  logic [IdxW-1:0]  first_idx;

  assign match_vec = match_raw & live;
  assign first_oh  = match_vec & (~match_vec + Depth'(1));
  assign found     = |match_vec;

  always_comb begin
    first_idx = '0;
    for (int i = 0; i < Depth; i++) begin
      if (first_oh[i]) begin
        first_idx = first_idx | IdxW'(i);
      end
    end
  end

  // ---------------------------------------------------------------- apply
  logic                     out_free, go_apply;
  logic                     full, empty;
  logic [CntW:0]            pos_w;
  olte_pkg::status_e        status_c;
  logic [IdxW-1:0]          fidx_c;
  logic                     up_c, down_c;
  logic [CntW-1:0]          count_c;

  assign out_free = !out_valid_o || !out_stall_i;
  assign go_apply = (state_q == StApply) && out_free;
  assign full     = (count_q >= limit_eff);
  assign empty    = (count_q == '0);
  assign pos_w    = (CntW+1)'(pos_q);

  always_comb begin
    status_c = olte_pkg::StatOk;
    fidx_c   = '0;
    up_c     = 1'b0;
    down_c   = 1'b0;
    at       = '0;
    count_c  = count_q;
    unique case (olte_pkg::cmd_e'(cmd_q))
      olte_pkg::CmdPushBack: begin
        if (full) begin
          status_c = olte_pkg::StatFull;
        end else begin
          up_c    = 1'b1;
          at      = count_q[IdxW-1:0];
          count_c = count_q + CntW'(1);
        end
      end
      olte_pkg::CmdPopBack: begin
        if (empty) begin
          status_c = olte_pkg::StatEmpty;
        end else begin
          count_c = count_q - CntW'(1);
        end
      end
      olte_pkg::CmdPushFront: begin
        if (full) begin
          status_c = olte_pkg::StatFull;
        end else begin
          up_c    = 1'b1;
          count_c = count_q + CntW'(1);
        end
      end
      olte_pkg::CmdPopFront: begin
        if (empty) begin
          status_c = olte_pkg::StatEmpty;
        end else begin
          down_c  = 1'b1;
          count_c = count_q - CntW'(1);
        end
      end
      olte_pkg::CmdInsert: begin
        if (full) begin
          status_c = olte_pkg::StatFull;
        end else if (pos_w == '0 || pos_w > ((CntW+1)'(count_q) + (CntW+1)'(1))) begin
          status_c = olte_pkg::StatBadPos;
        end else begin
          up_c    = 1'b1;
          at      = pos_q[IdxW-1:0] - IdxW'(1);
          count_c = count_q + CntW'(1);
        end
      end
      olte_pkg::CmdErase: begin
        if (empty) begin
          status_c = olte_pkg::StatEmpty;
        end else if (pos_w == '0 || pos_w > (CntW+1)'(count_q)) begin
          status_c = olte_pkg::StatBadPos;
        end else begin
          down_c  = 1'b1;
          at      = pos_q[IdxW-1:0] - IdxW'(1);
          count_c = count_q - CntW'(1);
        end
      end
      olte_pkg::CmdFind: begin
        if (!found) begin
          status_c = olte_pkg::StatNotFound;
        end else begin
          fidx_c = first_idx;
        end
      end
      olte_pkg::CmdRemove: begin
        if (!found) begin
          status_c = olte_pkg::StatNotFound;
        end else begin
          fidx_c  = first_idx;
          down_c  = 1'b1;
          at      = first_idx;
          count_c = count_q - CntW'(1);
        end
      end
      olte_pkg::CmdClear: begin
        count_c = '0;
      end
      default: begin
        // unknown command: no change, ok
      end
    endcase
  end

  assign ctl.shift_up   = go_apply && up_c;
  assign ctl.shift_down = go_apply && down_c;
  assign ctl.cmp_en     = (state_q == StCmp);
  assign count_d        = go_apply ? count_c : count_q;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept)   state_d = StCmp;
      StCmp:                 state_d = StApply;
      StApply: if (go_apply) state_d = StIdle;
      default:               state_d = StIdle;
    endcase
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (go_apply) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  logic [olte_pkg::StatusW-1:0] status_q;
  logic [olte_pkg::FidxW-1:0]   fidx_q;
  logic [olte_pkg::EcntW-1:0]   ecnt_q;
  logic                         empty_q;

  always_ff @(posedge clk_i) begin
    if (go_apply) begin
      status_q <= status_c;
      fidx_q   <= olte_pkg::FidxW'(fidx_c);
      ecnt_q   <= olte_pkg::EcntW'(count_c);
      empty_q  <= (count_c == '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_index_o = fidx_q;
  assign entry_count_o = ecnt_q;
  assign is_empty_o    = empty_q;

  // ---------------------------------------------------------------- checks
  a_accept_to_cmp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StCmp))
    else $error("accepted item did not enter compare pass");

  a_cmp_to_apply : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCmp) |=> (state_q == StApply))
    else $error("compare pass not followed by apply");

  a_first_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first_oh))
    else $error("first-match select not one-hot");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_apply |=> (count_q <= CntW'(Depth)))
    else $error("entry count exceeded depth");

  a_count_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !go_apply |=> $stable(count_q))
    else $error("count changed outside apply");

endmodule

`default_nettype wire
